FILE: sv/sis_pkg.sv
`default_nettype none

package sis_pkg;

  // Per-cycle command broadcast from the controller to every cell
  typedef struct packed {
    logic ins;  // insert the broadcast value into the chain
    logic pop;  // shift the chain one place towards cell 0
  } sis_ctrl_t;

endpackage

`default_nettype wire

FILE: sv/sis_cell.sv
`default_nettype none

module sis_cell #(
  parameter int DATA_WIDTH = 32
) (
  input  wire                    clk,
  input  wire sis_pkg::sis_ctrl_t ctrl,
  input  wire                    occ,
  input  wire  [DATA_WIDTH-1:0]  new_value,
  input  wire  [DATA_WIDTH-1:0]  left_value,
  input  wire                    left_gt,
  input  wire  [DATA_WIDTH-1:0]  right_value,
  output logic [DATA_WIDTH-1:0]  value,
  output logic                   gt
);

  logic [DATA_WIDTH-1:0] value_r;
  logic [DATA_WIDTH-1:0] value_nxt;

  // An empty cell counts as greater than anything, so it takes part in the shift
  assign gt    = !occ || ($signed(value_r) > $signed(new_value));
  assign value = value_r;

  // Take the new value at the insertion point, the left neighbour beyond it; on a pop, the right neighbour
  always_comb begin
    value_nxt = value_r;
    if (ctrl.ins && gt) begin
      if (left_gt) begin
        value_nxt = left_value;
      end else begin
        value_nxt = new_value;
      end
    end else if (ctrl.pop) begin
      value_nxt = right_value;
    end
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
  end

endmodule

`default_nettype wire

FILE: sv/stable_insertion_sorter.sv
`default_nettype none

// Stable insertion sorter. Signed values enter one per cycle on the input
// channel and are placed in a chain of MAX_ITEMS cells, after every stored
// value that is less than or equal to them, so equal values keep their
// arrival order. Every cell compares against the incoming value in the same
// cycle and shifts by one place, which sets the rate of one transfer per
// cycle while a set is collected. The transfer marked last is inserted too,
// and then the run of n stored values drains from cell 0, one result per
// cycle unless the output stalls, with the final one marked; the input
// stalls until the last one has left cell 0. Values beyond MAX_ITEMS are
// dropped and overflow is set on every result of that run.
module stable_insertion_sorter #(
  parameter int MAX_ITEMS  = 64,
  parameter int DATA_WIDTH = 32
) (
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire                    in_valid,
  output logic                   in_stall,
  input  wire  [DATA_WIDTH-1:0]  in_value,
  input  wire                    in_last,
  output logic                   out_valid,
  input  wire                    out_stall,
  output logic [DATA_WIDTH-1:0]  out_value_res,
  output logic                   out_last_res,
  output logic                   out_overflow
);

  localparam int COUNT_W = $clog2(MAX_ITEMS + 1);

  logic [COUNT_W-1:0]    count_r, count_nxt;
  logic [COUNT_W-1:0]    remaining_r, remaining_nxt;
  logic                  dropped_r, dropped_nxt;
  logic                  run_ovf_r, run_ovf_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [DATA_WIDTH-1:0] out_value_r, out_value_nxt;
  logic                  out_last_r, out_last_nxt;
  logic                  out_ovf_r, out_ovf_nxt;

  logic                  in_xfer;
  logic                  full;
  logic                  pop;
  sis_pkg::sis_ctrl_t    ctrl;

  logic [DATA_WIDTH-1:0] cell_value [MAX_ITEMS];
  logic                  cell_gt    [MAX_ITEMS];

  assign in_stall = (remaining_r != '0);
  assign in_xfer  = in_valid && !in_stall;
  assign full     = (count_r == COUNT_W'(MAX_ITEMS));
  assign pop      = (remaining_r != '0) && (!out_valid_r || !out_stall);

  assign ctrl.ins = in_xfer && !full;
  assign ctrl.pop = pop;

  // Build the chain of cells
  for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
    logic [DATA_WIDTH-1:0] left_value;
    logic                  left_gt;
    logic [DATA_WIDTH-1:0] right_value;

    if (i == 0) begin : g_first
      assign left_value = '0;
      assign left_gt    = 1'b0;
    end else begin : g_inner
      assign left_value = cell_value[i-1];
      assign left_gt    = cell_gt[i-1];
    end

    if (i == MAX_ITEMS - 1) begin : g_tail
      assign right_value = '0;
    end else begin : g_body
      assign right_value = cell_value[i+1];
    end

    sis_cell #(
      .DATA_WIDTH (DATA_WIDTH)
    ) u_cell (
      .clk         (clk),
      .ctrl        (ctrl),
      .occ         (COUNT_W'(i) < count_r),
      .new_value   (in_value),
      .left_value  (left_value),
      .left_gt     (left_gt),
      .right_value (right_value),
      .value       (cell_value[i]),
      .gt          (cell_gt[i])
    );
  end

  // Track fill level and drain progress; hand cell 0 to the output register
  always_comb begin
    count_nxt     = count_r;
    remaining_nxt = remaining_r;
    dropped_nxt   = dropped_r;
    run_ovf_nxt   = run_ovf_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_value_nxt = out_value_r;
    out_last_nxt  = out_last_r;
    out_ovf_nxt   = out_ovf_r;

    if (in_xfer) begin
      if (full) begin
        dropped_nxt = 1'b1;
      end else begin
        count_nxt = count_r + COUNT_W'(1);
      end
      if (in_last) begin
        remaining_nxt = count_nxt;
        run_ovf_nxt   = dropped_nxt;
        count_nxt     = '0;
        dropped_nxt   = 1'b0;
      end
    end

    if (pop) begin
      out_valid_nxt = 1'b1;
      out_value_nxt = cell_value[0];
      out_last_nxt  = (remaining_r == COUNT_W'(1));
      out_ovf_nxt   = run_ovf_r;
      remaining_nxt = remaining_r - COUNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      remaining_r <= '0;
      dropped_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      remaining_r <= remaining_nxt;
      dropped_r   <= dropped_nxt;
      out_valid_r <= out_valid_nxt;
    end
    run_ovf_r   <= run_ovf_nxt;
    out_value_r <= out_value_nxt;
    out_last_r  <= out_last_nxt;
    out_ovf_r   <= out_ovf_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_value_res = out_value_r;
  assign out_last_res  = out_last_r;
  assign out_overflow  = out_ovf_r;

`ifndef NO_ASSERTIONS
  a_count_bound : assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= COUNT_W'(MAX_ITEMS))
    else $error("fill count beyond capacity");

  a_out_hold : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_stall |=> out_valid_r && $stable(out_value_r) &&
      $stable(out_last_r) && $stable(out_ovf_r))
    else $error("stalled result changed");

  a_last_starts_drain : assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer && in_last |=> remaining_r != '0 && count_r == '0)
    else $error("last transfer did not start a drain");
`endif

endmodule

`default_nettype wire

FILE: dv/stable_insertion_sorter_test.sv
`default_nettype none

module stable_insertion_sorter_test;

  localparam int MAX_ITEMS   = 64;
  localparam int DATA_W      = 32;
  localparam int QUIET_LIMIT = 2000;
  localparam int HOLD_CYCLES = 150;

  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic                     last;
    logic                     wait_idle;  // offer only once every result is back
  } send_item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic                     last;
    logic                     overflow;
  } sorted_res_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [DATA_W-1:0] in_value = '0;
  logic              in_last = 1'b0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [DATA_W-1:0] out_value_res;
  logic              out_last_res;
  logic              out_overflow;

  send_item_t               pending[$];
  sorted_res_t              sorted_exp[$];
  logic signed [DATA_W-1:0] stored_vals[$];
  logic                     overflowed = 1'b0;

  int  n_items = 0;
  int  n_sets = 0;
  int  n_results = 0;
  int  n_ovf_runs = 0;
  int  longest_run = 0;
  int  errors = 0;
  int  quiet = 0;
  int  send_gap = 0;
  int  recv_gap = 0;
  int  hold_left = 0;
  bit  hold_done = 1'b0;
  bit  send_burst = 1'b0;
  bit  recv_burst = 1'b0;

  stable_insertion_sorter #(
    .MAX_ITEMS (MAX_ITEMS),
    .DATA_WIDTH(DATA_W)
  ) i_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_value     (in_value),
    .in_last      (in_last),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_value_res(out_value_res),
    .out_last_res (out_last_res),
    .out_overflow (out_overflow)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Place a value after every stored value not greater than it, or mark overflow when full; flush on last
  task automatic sort_insert(input logic signed [DATA_W-1:0] v, input logic is_last);
    int pos;
    int n;
    sorted_res_t r;
    n_items++;
    if (stored_vals.size() >= MAX_ITEMS) begin
      overflowed = 1'b1;
    end else begin
      pos = stored_vals.size();
      while (pos > 0 && stored_vals[pos-1] > v) pos--;
      stored_vals.insert(pos, v);
    end
    if (is_last) begin
      n = stored_vals.size();
      for (int k = 0; k < n; k++) begin
        r.value    = stored_vals[k];
        r.last     = (k == n - 1);
        r.overflow = overflowed;
        sorted_exp.insert(sorted_exp.size(), r);
      end
      n_sets++;
      if (overflowed) n_ovf_runs++;
      if (n > longest_run) longest_run = n;
      stored_vals.delete();
      overflowed = 1'b0;
    end
  endtask

  // Wait before the next transfer, with occasional runs of back-to-back ones
  function automatic int draw_gap(inout bit burst);
    if ($urandom_range(0, 15) == 0) burst = !burst;
    return burst ? 0 : $urandom_range(0, 9);
  endfunction

  function automatic logic [DATA_W-1:0] draw_value();
    case ($urandom_range(0, 3))
      0:       return $urandom_range(0, 8) - 4;
      1:       return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7fff_ffff;
      default: return $urandom;
    endcase
  endfunction

  task automatic add_item(input logic [DATA_W-1:0] v, input logic is_last,
                          input logic wait_idle = 1'b0);
    send_item_t it;
    it.value     = v;
    it.last      = is_last;
    it.wait_idle = wait_idle;
    pending.insert(pending.size(), it);
  endtask

  task automatic note_fail(input string msg);
    errors++;
    if (errors <= 10) $display("%t: %s", $realtime, msg);
  endtask

  // Sender: hold a stalled transfer, otherwise advance to the next pending item
  always @(posedge clk) begin : drive
    send_item_t it;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) sort_insert(in_value, in_last);
      if (!(in_valid && in_stall)) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (pending.size() > 0 &&
                     !(pending[0].wait_idle && sorted_exp.size() > 0)) begin
          it = pending.pop_front();
          in_valid <= 1'b1;
          in_value <= it.value;
          in_last  <= it.last;
          send_gap = draw_gap(send_burst);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: check each transfer against the oldest expected result
  always @(posedge clk) begin : observe
    sorted_res_t e;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        n_results++;
        if (sorted_exp.size() == 0) begin
          note_fail($sformatf("unexpected result value=%0d last=%0b overflow=%0b",
                              $signed(out_value_res), out_last_res, out_overflow));
        end else begin
          e = sorted_exp.pop_front();
          if (out_value_res !== e.value || out_last_res !== e.last ||
              out_overflow !== e.overflow)
            note_fail($sformatf({"result %0d: expected value=%0d last=%0b ",
                                 "overflow=%0b, got value=%0d last=%0b overflow=%0b"},
                                n_results, e.value, e.last, e.overflow,
                                $signed(out_value_res), out_last_res, out_overflow));
        end
        recv_gap = draw_gap(recv_burst);
      end
      // one long hold-off once the random part is under way
      if (!hold_done && n_results >= 20) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (recv_gap > 0) begin
        recv_gap--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Watchdog: end the run when nothing has moved for too long
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet <= 0;
      else quiet <= quiet + 1;
      if (quiet >= QUIET_LIMIT) begin
        $display("timeout: no transfer for %0d cycles, %0d results outstanding",
                 quiet, sorted_exp.size());
        $display("stable_insertion_sorter_test NOT OK");
        $finish;
      end
    end
  end

  initial begin
    int n_rand_sets;
    int big_over;
    int sz;

    // extremes, duplicates and a mix of signs in one set
    add_item(32'h0000_0000, 1'b0);
    add_item(32'hffff_ffff, 1'b0);
    add_item(32'h7fff_ffff, 1'b0);
    add_item(32'h8000_0000, 1'b0);
    add_item(32'h0000_0005, 1'b0);
    add_item(32'hffff_ffff, 1'b0);
    add_item(32'h0000_0001, 1'b1);
    // set of a single item
    add_item(32'h8000_0000, 1'b1);
    // alternating bit patterns, then small values in descending order
    add_item(32'h5555_5555, 1'b0);
    add_item(32'haaaa_aaaa, 1'b0);
    add_item(32'h0000_0003, 1'b0);
    add_item(32'h0000_0002, 1'b0);
    add_item(32'h0000_0001, 1'b0);
    add_item(32'h0000_0000, 1'b1);
    // equal values only
    add_item(32'h0000_0007, 1'b0);
    add_item(32'h0000_0007, 1'b0);
    add_item(32'h0000_0007, 1'b1);

    // random sets: mostly short, one that fills the chain and runs past capacity
    n_rand_sets = 14;
    big_over = $urandom_range(0, n_rand_sets - 1);
    for (int s = 0; s < n_rand_sets; s++) begin
      if (s == big_over) sz = MAX_ITEMS + $urandom_range(1, 4);
      else               sz = $urandom_range(1, 6);
      for (int k = 0; k < sz; k++)
        add_item(draw_value(), k == sz - 1, s == 0 && k == 0);
    end

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    while (pending.size() > 0 || in_valid || sorted_exp.size() > 0) @(negedge clk);
    repeat (20) @(posedge clk);

    $display("sent %0d items in %0d sets, received %0d results", n_items, n_sets,
             n_results);
    $display("longest run %0d, %0d runs with overflow, %0d mismatches", longest_run,
             n_ovf_runs, errors);
    if (errors == 0) begin
      $display("stable_insertion_sorter_test OK");
    end else begin
      $display("stable_insertion_sorter_test NOT OK");
    end
    $finish;
  end

endmodule

`default_nettype wire
